/* rtl/suk_pkg.sv */
package suk_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned CAP_W         = 6;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned LIM_W         = 7;
  localparam int unsigned TDATA_OUT_W   = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_DUP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_DUMP      = 3'd5
  } status_e;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] value;
    logic             last;
  } res_t;

endpackage

/* rtl/suk_ram.sv */
module suk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/suk_obuf.sv */
module suk_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  suk_pkg::res_t res_i,
  output logic          res_ready_o,
  output logic          out_valid_o,
  output suk_pkg::res_t out_o,
  input  logic          out_ready_i
);

  logic          valid_q, valid_d;
  suk_pkg::res_t data_q;
  logic          push;

  assign res_ready_o = !valid_q || out_ready_i;
  assign push        = res_valid_i && res_ready_o;
  assign valid_d     = push || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

/* rtl/suk_seq.sv */
module suk_seq #(
  parameter int unsigned DEPTH = suk_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [suk_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  suk_pkg::op_e                      in_op_i,
  input  logic signed [suk_pkg::KEY_W-1:0]  in_key_i,
  output logic                              res_valid_o,
  output suk_pkg::res_t                     res_o,
  input  logic                              res_ready_i,
  output logic                              mem_we_o,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [suk_pkg::KEY_W-1:0]         mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_o,
  input  logic [suk_pkg::KEY_W-1:0]         mem_rdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DUMP = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e                           state_q, state_d;
  suk_pkg::op_e                     op_q, op_d;
  logic signed [suk_pkg::KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]                    idx_q, idx_d;
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic [suk_pkg::CAP_W-1:0]        cap_q;
  logic                             flag_q, flag_d;
  logic [suk_pkg::KEY_W-1:0]        carry_q, carry_d;
  logic [suk_pkg::POS_W-1:0]        pos_q, pos_d;
  suk_pkg::res_t                    res_q, res_d;

  logic [CW-1:0]                    idx_inc;
  logic                             at_end;
  logic signed [suk_pkg::KEY_W-1:0] rd;
  logic                             eq, rd_lt_key, key_lt_rd;
  logic [suk_pkg::LIM_W-1:0]        lim;
  logic                             full;

  assign idx_inc   = idx_q + 1'b1;
  assign at_end    = (idx_q == cnt_q);
  assign rd        = $signed(mem_rdata_i);
  assign eq        = (rd == key_q);
  assign rd_lt_key = (rd < key_q);
  assign key_lt_rd = (key_q < rd);
  assign lim       = (suk_pkg::LIM_W'(cap_q) < suk_pkg::LIM_W'(DEPTH))
                   ? suk_pkg::LIM_W'(cap_q) : suk_pkg::LIM_W'(DEPTH);
  assign full      = (suk_pkg::LIM_W'(cnt_q) >= lim);
  assign in_ready_o = (state_q == S_IDLE);

  function automatic suk_pkg::res_t mk_res(suk_pkg::status_e st, logic fnd,
                                           logic [suk_pkg::POS_W-1:0] p);
    suk_pkg::res_t r;
    r.status = st;
    r.found  = fnd;
    r.pos    = p;
    r.value  = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;
    carry_d     = carry_q;
    pos_d       = pos_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AW-1:0];
    mem_wdata_o = carry_q;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    res_o       = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_op_i;
          key_d  = in_key_i;
          idx_d  = '0;
          flag_d = 1'b0;
          unique case (in_op_i)
            suk_pkg::OP_INSERT: begin
              if (full) begin
                res_d   = mk_res(suk_pkg::ST_FULL, 1'b0, '0);
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            suk_pkg::OP_REMOVE: begin
              if (cnt_q == '0) begin
                res_d   = mk_res(suk_pkg::ST_EMPTY, 1'b0, '0);
                state_d = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            suk_pkg::OP_SEARCH: begin
              state_d = S_SCAN;
            end
            suk_pkg::OP_DUMP: begin
              if (cnt_q == '0) begin
                res_d   = mk_res(suk_pkg::ST_EMPTY, 1'b0, '0);
                state_d = S_RESP;
              end else begin
                state_d = S_DUMP;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_raddr_o = idx_inc[AW-1:0];
        unique case (op_q)
          suk_pkg::OP_INSERT: begin
            if (!flag_q) begin
              if (at_end || !rd_lt_key) begin
                if (!at_end && eq) begin
                  res_d   = mk_res(suk_pkg::ST_DUP, 1'b1, suk_pkg::POS_W'(idx_q));
                  state_d = S_RESP;
                end else begin
                  mem_we_o    = 1'b1;
                  mem_wdata_o = key_q;
                  carry_d     = mem_rdata_i;
                  flag_d      = 1'b1;
                  pos_d       = suk_pkg::POS_W'(idx_q);
                  if (at_end) begin
                    cnt_d   = cnt_q + 1'b1;
                    res_d   = mk_res(suk_pkg::ST_DONE, 1'b0, suk_pkg::POS_W'(idx_q));
                    state_d = S_RESP;
                  end else begin
                    idx_d = idx_inc;
                  end
                end
              end else begin
                idx_d = idx_inc;
              end
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = carry_q;
              carry_d     = mem_rdata_i;
              if (at_end) begin
                cnt_d   = cnt_q + 1'b1;
                res_d   = mk_res(suk_pkg::ST_DONE, 1'b0, pos_q);
                state_d = S_RESP;
              end else begin
                idx_d = idx_inc;
              end
            end
          end
          suk_pkg::OP_REMOVE: begin
            if (!flag_q) begin
              if (at_end || key_lt_rd) begin
                res_d   = mk_res(suk_pkg::ST_NOT_FOUND, 1'b0, '0);
                state_d = S_RESP;
              end else begin
                if (eq) begin
                  flag_d = 1'b1;
                  pos_d  = suk_pkg::POS_W'(idx_q);
                end
                idx_d = idx_inc;
              end
            end else begin
              if (at_end) begin
                cnt_d   = cnt_q - 1'b1;
                res_d   = mk_res(suk_pkg::ST_DONE, 1'b1, pos_q);
                state_d = S_RESP;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(idx_q - 1'b1);
                mem_wdata_o = mem_rdata_i;
                idx_d       = idx_inc;
              end
            end
          end
          suk_pkg::OP_SEARCH: begin
            if (at_end || key_lt_rd) begin
              res_d   = mk_res(suk_pkg::ST_NOT_FOUND, 1'b0, '0);
              state_d = S_RESP;
            end else if (eq) begin
              res_d   = mk_res(suk_pkg::ST_DONE, 1'b1, suk_pkg::POS_W'(idx_q));
              state_d = S_RESP;
            end else begin
              idx_d = idx_inc;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_DUMP: begin
        res_valid_o  = 1'b1;
        res_o.status = suk_pkg::ST_DUMP;
        res_o.found  = 1'b0;
        res_o.pos    = suk_pkg::POS_W'(idx_q);
        res_o.value  = mem_rdata_i;
        res_o.last   = (idx_inc == cnt_q);
        if (res_ready_i) begin
          mem_raddr_o = idx_inc[AW-1:0];
          if (idx_inc == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end else begin
          mem_raddr_o = idx_q[AW-1:0];
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cap_q   <= suk_pkg::CAP_RESET;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      flag_q  <= flag_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    idx_q   <= idx_d;
    carry_q <= carry_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
  end

endmodule

/* rtl/sorted_unique_key_list_top.sv */
// Sorted list of unique signed 32-bit keys held in one DEPTH x 32 RAM.
// Input stream: s_axis_tuser carries the operation (insert, remove, search,
// dump), s_axis_tdata the key. One transaction is taken at a time; tready is
// high only while the sequencer is idle.
// Output stream: one result per insert, remove or search; a dump gives one
// result per stored key (tlast on the last) or a single empty result.
// Insert and remove walk the RAM one entry a cycle through its single read
// port; search stops at the first key not below the target; a dump gives one
// key per cycle while the output is not stalled. Full, empty and empty-dump
// cases give their result without a walk. A result waits in the output
// register, and the next transaction is accepted while it waits.
// When the receiver stalls, a dump holds its RAM read address and resumes at
// the same key; other operations hold their result until taken.
// Reset clears the key count and sets capacity to 32; RAM contents are not
// cleared and need no clearing pass. cfg_we_i writes capacity; write it only
// while idle.
module sorted_unique_key_list_top #(
  parameter int unsigned DEPTH = suk_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [suk_pkg::CAP_W-1:0]             cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] key
  input  logic [suk_pkg::KEY_W-1:0]             s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [0] found, [5:1] position, [37:6] value, [39:38] zero
  output logic [suk_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
  // [2:0] status
  output logic [2:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [suk_pkg::KEY_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [suk_pkg::KEY_W-1:0] mem_rdata;

  logic          res_valid;
  logic          res_ready;
  suk_pkg::res_t res;
  suk_pkg::res_t out;

  suk_ram #(
    .WIDTH (suk_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  suk_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (suk_pkg::op_e'(s_axis_tuser)),
    .in_key_i    ($signed(s_axis_tdata)),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  suk_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out.value, out.pos, out.found};
  assign m_axis_tuser = out.status;
  assign m_axis_tlast = out.last;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import suk_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 43;

  class sorted_list_sb;
    logic signed [KEY_W-1:0] keys[DEPTH];
    int unsigned key_cnt;
    logic [CAP_W-1:0] cap;
    res_t pending_results[$];
    int unsigned errors;

    function new();
      key_cnt = 0;
      cap = CAP_RESET;
      errors = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void queue_result(status_e status, logic found, int unsigned pos,
                               logic [KEY_W-1:0] value, logic last);
      res_t r;
      r.status = status;
      r.found = found;
      r.pos = POS_W'(pos);
      r.value = value;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function int find_key(logic signed [KEY_W-1:0] key);
      for (int unsigned i = 0; i < key_cnt; i++) begin
        if (keys[i] == key) return int'(i);
      end
      return -1;
    endfunction

    function void note_op(op_e op, logic signed [KEY_W-1:0] key);
      int unsigned lim;
      int unsigned i;
      int p;
      lim = (cap < DEPTH) ? cap : DEPTH;
      case (op)
        OP_INSERT: begin
          if (key_cnt >= lim) begin
            queue_result(ST_FULL, 1'b0, 0, '0, 1'b1);
          end else begin
            i = 0;
            while (i < key_cnt && keys[i] < key) i++;
            if (i < key_cnt && keys[i] == key) begin
              queue_result(ST_DUP, 1'b1, i, '0, 1'b1);
            end else begin
              for (int unsigned j = key_cnt; j > i; j--) keys[j] = keys[j-1];
              keys[i] = key;
              key_cnt++;
              queue_result(ST_DONE, 1'b0, i, '0, 1'b1);
            end
          end
        end
        OP_REMOVE: begin
          p = find_key(key);
          if (key_cnt == 0) begin
            queue_result(ST_EMPTY, 1'b0, 0, '0, 1'b1);
          end else if (p < 0) begin
            queue_result(ST_NOT_FOUND, 1'b0, 0, '0, 1'b1);
          end else begin
            for (int unsigned j = p; j + 1 < key_cnt; j++) keys[j] = keys[j+1];
            key_cnt--;
            queue_result(ST_DONE, 1'b1, p, '0, 1'b1);
          end
        end
        OP_SEARCH: begin
          p = find_key(key);
          if (p < 0) queue_result(ST_NOT_FOUND, 1'b0, 0, '0, 1'b1);
          else queue_result(ST_DONE, 1'b1, p, '0, 1'b1);
        end
        default: begin
          if (key_cnt == 0) begin
            queue_result(ST_EMPTY, 1'b0, 0, '0, 1'b1);
          end else begin
            for (int unsigned j = 0; j < key_cnt; j++)
              queue_result(ST_DUMP, 1'b0, j, keys[j], j + 1 == key_cnt);
          end
        end
      endcase
    endfunction

    function void report(string field, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      report("status", exp_r.status, got.status);
      report("found", exp_r.found, got.found);
      report("position", exp_r.pos, got.pos);
      report("value", exp_r.value, got.value);
      report("last", exp_r.last, got.last);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CAP_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [KEY_W-1:0]       s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  sorted_list_sb sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  sorted_unique_key_list_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.found = m_axis_tdata[0];
        got.pos = m_axis_tdata[5:1];
        got.value = m_axis_tdata[37:6];
        got.last = m_axis_tlast;
        sb.check_result(got);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic set_idling(int unsigned mode);
    case (mode)
      1: begin sender_idle_pct = 84; rx_stall_pct = 0; end
      2: begin sender_idle_pct = 0; rx_stall_pct = 84; end
      3: begin sender_idle_pct = 20; rx_stall_pct = 20; end
      default: begin sender_idle_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  task automatic send_op(op_e op, logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op, key);
  endtask

  // hold off until every result is out and the block is idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || !s_axis_tready);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.cap = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] edge_keys[6];
    int unsigned r;
    edge_keys = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                  32'h8000_0001, 32'h7fff_fffe};
    r = $urandom_range(0, 99);
    if (r < 45 && sb.key_cnt > 0) return sb.keys[$urandom_range(0, sb.key_cnt - 1)];
    if (r < 80) return KEY_W'(int'($urandom_range(0, 80)) - 40);
    if (r < 90) return edge_keys[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned ins_pct, int unsigned mode);
    op_e op;
    int unsigned s;
    write_capacity(cap);
    set_idling(mode);
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      s = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < ins_pct) op = OP_INSERT;
      else if (s < 2) op = OP_DUMP;
      else if (s < 6) op = OP_REMOVE;
      else op = OP_SEARCH;
      send_op(op, pick_key());
    end
  endtask

  initial begin
    op_e dir_ops[18];
    logic [KEY_W-1:0] dir_keys[18];
    dir_ops = '{OP_DUMP, OP_REMOVE, OP_SEARCH, OP_INSERT, OP_INSERT, OP_INSERT,
                OP_INSERT, OP_INSERT, OP_INSERT, OP_SEARCH, OP_SEARCH, OP_REMOVE,
                OP_REMOVE, OP_REMOVE, OP_DUMP, OP_INSERT, OP_INSERT, OP_DUMP};
    dir_keys = '{32'h0, 32'h5, 32'h5, 32'h0, 32'h8000_0000, 32'h7fff_ffff,
                 32'hffff_ffff, 32'h1, 32'h0, 32'hffff_ffff, 32'h2, 32'h7,
                 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'haaaa_aaaa,
                 32'h5555_5555, 32'h0};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_INSERT;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < 18; i++) send_op(dir_ops[i], dir_keys[i]);

    run_phase(6'd63, 80, 0);
    run_phase(6'd3, 50, 1);
    run_phase(6'd0, 30, 2);
    run_phase(6'd32, 70, 3);
    run_phase(6'd1, 40, 0);
    run_phase(6'd40, 75, 2);
    run_phase(6'd17, 35, 1);
    run_phase(6'd32, 20, 3);

    drain();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
